@@ src/svr_pkg.sv @@
package svr_pkg;

	localparam int MAX_WIDTH_DEF     = 1024;
	localparam int MAX_HEIGHT_DEF    = 1024;
	localparam int PALETTE_DEPTH_DEF = 256;
	localparam int QUEUE_DEPTH       = 2;
	localparam int CFG_W             = 11;

	localparam logic [1:0] CMD_LINE    = 2'd0;
	localparam logic [1:0] CMD_DATA    = 2'd1;
	localparam logic [1:0] CMD_PALETTE = 2'd2;

	localparam logic [2:0] MODE_RGB        = 3'd0;
	localparam logic [2:0] MODE_RGBA       = 3'd1;
	localparam logic [2:0] MODE_GRAY       = 3'd2;
	localparam logic [2:0] MODE_GRAY_ALPHA = 3'd3;
	localparam logic [2:0] MODE_INDEXED    = 3'd4;

	localparam logic [1:0] REG_PIXEL_MODE    = 2'd0;
	localparam logic [1:0] REG_CANVAS_WIDTH  = 2'd1;
	localparam logic [1:0] REG_CANVAS_HEIGHT = 2'd2;
	localparam logic [1:0] REG_PALETTE_VALID = 2'd3;

	localparam logic [1:0] BP_FIRST  = 2'd0;
	localparam logic [1:0] BP_SECOND = 2'd1;
	localparam logic [1:0] BP_THIRD  = 2'd2;
	localparam logic [1:0] BP_FOURTH = 2'd3;

	localparam logic [7:0] RED_MASK   = 8'hF8;
	localparam logic [7:0] GREEN_MASK = 8'hFC;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [11:0] line_row;
		logic [10:0]        line_width;
		logic [7:0]         data_byte;
		logic [7:0]         palette_index;
		logic [23:0]        palette_rgb;
	} svr_in_t;

	typedef struct packed {
		logic [19:0] pixel_addr;
		logic [15:0] pixel_value;
	} svr_out_t;

	typedef struct packed {
		logic [19:0] addr;
		logic [23:0] rgb;
	} svr_job_t;

	function automatic logic [15:0] to565(input logic [23:0] rgb);
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		r = rgb[23:16] & RED_MASK;
		g = rgb[15:8] & GREEN_MASK;
		b = rgb[7:0];
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

endpackage

@@ src/svr_if.sv @@
interface svr_in_if;
	logic             valid;
	logic             ready;
	svr_pkg::svr_in_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface svr_out_if;
	logic              valid;
	logic              ready;
	svr_pkg::svr_out_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

@@ src/svr_ram.sv @@
module svr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ src/svr_front.sv @@
module svr_front #(
	parameter int MAX_WIDTH     = svr_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT    = svr_pkg::MAX_HEIGHT_DEF,
	parameter int PALETTE_DEPTH = svr_pkg::PALETTE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_idx,
	input  logic [svr_pkg::CFG_W-1:0]  cfg_wdata,
	svr_in_if.sink                     scan,
	output logic                       push,
	output svr_pkg::svr_job_t          job,
	input  logic                       q_full
);
	import svr_pkg::*;

	localparam int AW = $clog2(PALETTE_DEPTH);

	logic [2:0]  pixel_mode_q;
	logic [10:0] canvas_width_q;
	logic [10:0] canvas_height_q;
	logic        palette_valid_q;

	logic        line_active_q;
	logic [19:0] row_base_q;
	logic [10:0] clipped_width_q;
	logic [10:0] column_count_q;
	logic [1:0]  byte_phase_q;
	logic [7:0]  red_hold_q;
	logic [7:0]  green_hold_q;

	logic        valid_s1;
	logic [19:0] addr_s1;
	logic [23:0] rgb_s1;
	logic        pal_sel_s1;

	svr_in_t     p;
	logic        accept;
	logic [10:0] cw;
	logic [10:0] ch;
	logic        row_ok;
	logic [21:0] prod;
	logic        in_line;
	logic [7:0]  b;
	logic [1:0]  ph_n;
	logic [7:0]  red_n;
	logic [7:0]  green_n;
	logic        emit;
	logic        use_pal;
	logic [23:0] rgb_n;
	logic        pal_we;
	logic        pal_re;
	logic [23:0] pal_rdata;

	assign p          = scan.payload;
	assign scan.ready = !valid_s1 || !q_full;
	assign accept     = scan.valid && scan.ready;
	assign b          = p.data_byte;

	assign cw = (int'(canvas_width_q) > MAX_WIDTH) ? 11'(MAX_WIDTH) : canvas_width_q;
	assign ch = (int'(canvas_height_q) > MAX_HEIGHT) ? 11'(MAX_HEIGHT) : canvas_height_q;

	assign row_ok  = !p.line_row[11] && (p.line_row[10:0] < ch);
	assign prod    = 22'(p.line_row[10:0]) * 22'(cw);
	assign in_line = line_active_q && (column_count_q < clipped_width_q);

	// byte grouping per pixel mode
	always_comb begin
		ph_n    = byte_phase_q;
		red_n   = red_hold_q;
		green_n = green_hold_q;
		emit    = 1'b0;
		use_pal = 1'b0;
		rgb_n   = {b, b, b};
		if (p.command == CMD_DATA && in_line) begin
			unique case (pixel_mode_q)
				MODE_RGB, MODE_RGBA: begin
					if (byte_phase_q == BP_FOURTH && pixel_mode_q == MODE_RGBA) begin
						ph_n = BP_FIRST;
					end else if (byte_phase_q == BP_FIRST || byte_phase_q == BP_FOURTH) begin
						red_n = b;
						ph_n  = BP_SECOND;
					end else if (byte_phase_q == BP_SECOND) begin
						green_n = b;
						ph_n    = BP_THIRD;
					end else begin
						emit  = 1'b1;
						rgb_n = {red_hold_q, green_hold_q, b};
						ph_n  = (pixel_mode_q == MODE_RGBA) ? BP_FOURTH : BP_FIRST;
					end
				end
				MODE_GRAY: begin
					ph_n = BP_FIRST;
					emit = 1'b1;
				end
				MODE_GRAY_ALPHA: begin
					if (byte_phase_q != BP_FIRST) begin
						ph_n = BP_FIRST;
					end else begin
						ph_n = BP_SECOND;
						emit = 1'b1;
					end
				end
				MODE_INDEXED: begin
					if (palette_valid_q) begin
						ph_n = BP_FIRST;
						emit = 1'b1;
						if (int'(b) < PALETTE_DEPTH) begin
							use_pal = 1'b1;
						end else begin
							rgb_n = '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign pal_we = accept && p.command == CMD_PALETTE && int'(p.palette_index) < PALETTE_DEPTH;
	assign pal_re = accept && use_pal;

	svr_ram #(
		.WIDTH(24),
		.DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk  (clk),
		.we   (pal_we),
		.waddr(p.palette_index[AW-1:0]),
		.wdata(p.palette_rgb),
		.re   (pal_re),
		.raddr(b[AW-1:0]),
		.rdata(pal_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_mode_q    <= MODE_RGB;
			canvas_width_q  <= 11'(MAX_WIDTH_DEF);
			canvas_height_q <= 11'(MAX_HEIGHT_DEF);
			palette_valid_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_PIXEL_MODE:    pixel_mode_q    <= cfg_wdata[2:0];
				REG_CANVAS_WIDTH:  canvas_width_q  <= cfg_wdata[10:0];
				REG_CANVAS_HEIGHT: canvas_height_q <= cfg_wdata[10:0];
				REG_PALETTE_VALID: palette_valid_q <= cfg_wdata[0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_active_q   <= 1'b0;
			row_base_q      <= '0;
			clipped_width_q <= '0;
			column_count_q  <= '0;
			byte_phase_q    <= BP_FIRST;
			red_hold_q      <= '0;
			green_hold_q    <= '0;
		end else if (accept) begin
			if (p.command == CMD_LINE) begin
				if (row_ok) begin
					line_active_q   <= 1'b1;
					row_base_q      <= prod[19:0];
					clipped_width_q <= (p.line_width > cw) ? cw : p.line_width;
					column_count_q  <= '0;
					byte_phase_q    <= BP_FIRST;
				end else begin
					line_active_q <= 1'b0;
				end
			end else begin
				byte_phase_q <= ph_n;
				red_hold_q   <= red_n;
				green_hold_q <= green_n;
				if (emit) begin
					column_count_q <= column_count_q + 11'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan.ready) begin
			valid_s1 <= accept && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			addr_s1    <= row_base_q + 20'(column_count_q);
			rgb_s1     <= rgb_n;
			pal_sel_s1 <= use_pal;
		end
	end

	assign push     = valid_s1 && !q_full;
	assign job.addr = addr_s1;
	assign job.rgb  = pal_sel_s1 ? pal_rdata : rgb_s1;

	a_pal_read: assert property (@(posedge clk) disable iff (!arst_n)
		pal_re |=> valid_s1 && pal_sel_s1)
		else $error("palette read without a matching pixel");

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		column_count_q <= clipped_width_q)
		else $error("column count past clipped width");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && q_full |=> valid_s1 && $stable(addr_s1) && $stable(pal_sel_s1))
		else $error("stalled pixel lost or changed");

endmodule

@@ src/svr_queue.sv @@
module svr_queue #(
	parameter int DEPTH = svr_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  svr_pkg::svr_job_t push_job,
	output logic              full,
	output logic              q_valid,
	output svr_pkg::svr_job_t q_job,
	input  logic              pop
);
	import svr_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	svr_job_t      mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign q_valid = (count_q != '0);
	assign q_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

@@ src/svr_back.sv @@
module svr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  svr_pkg::svr_job_t q_job,
	output logic              pop,
	svr_out_if.source         canvas
);
	import svr_pkg::*;

	logic     out_valid_q;
	svr_out_t pixel_q;

	assign pop            = q_valid && (!out_valid_q || canvas.ready);
	assign canvas.valid   = out_valid_q;
	assign canvas.payload = pixel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (canvas.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pixel_q.pixel_addr  <= q_job.addr;
			pixel_q.pixel_value <= to565(q_job.rgb);
		end
	end

endmodule

@@ src/scanline_to_rgb565_writer.sv @@
// Turns a stream of decoded scanline bytes into RGB565 canvas writes. The block takes one item
// per clock on scan (line start, pixel byte or palette write) unless a pixel waits on a full
// queue, and gives at most one write per item on canvas via the front's pixel register, queue
// and output register. The rate of one item per cycle is set by the front's line state update
// and the single palette read port, read in the cycle a palette index byte is taken. A short
// queue before the output register lets input go on while a write waits on canvas, until it
// fills. Palette entries must be written before indexed pixels use them; there is no clearing
// pass after reset. Configuration must be written only while idle; the block does not check it.
module scanline_to_rgb565_writer #(
	parameter int MAX_WIDTH     = svr_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT    = svr_pkg::MAX_HEIGHT_DEF,
	parameter int PALETTE_DEPTH = svr_pkg::PALETTE_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_idx,
	input  logic [svr_pkg::CFG_W-1:0] cfg_wdata,
	svr_in_if.sink                    scan,
	svr_out_if.source                 canvas
);
	import svr_pkg::*;

	logic     push;
	svr_job_t push_job;
	logic     q_full;
	logic     q_valid;
	svr_job_t q_job;
	logic     pop;

	svr_front #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_HEIGHT   (MAX_HEIGHT),
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.scan     (scan),
		.push     (push),
		.job      (push_job),
		.q_full   (q_full)
	);

	svr_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.full    (q_full),
		.q_valid (q_valid),
		.q_job   (q_job),
		.pop     (pop)
	);

	svr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(q_valid),
		.q_job  (q_job),
		.pop    (pop),
		.canvas (canvas)
	);

endmodule
